FILE: sv/two_way_traffic_light_controller_macros.svh
// assertion macros for the two-way traffic light controller
// included by the top level; no other dependencies
`ifndef TWO_WAY_TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH
`define TWO_WAY_TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlc assertion failed");
// next-cycle implication
`define TLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlc assertion failed");
`else
`define TLC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TLC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/tlc_pkg.sv
// shared types, codes and helpers of the traffic light controller
// no dependencies
package tlc_pkg;

   localparam int TLC_DEFAULT_RED   = 5;
   localparam int TLC_DEFAULT_AMBER = 2;
   localparam int TLC_DEFAULT_GREEN = 3;
   localparam int TLC_MAX_SECONDS   = 99;
   localparam logic [7:0] TLC_TIMEOUT_RESET = 8'd10;

   typedef enum logic [1:0] {
      COL_RED   = 2'd0,
      COL_AMBER = 2'd1,
      COL_GREEN = 2'd2
   } color_type;

   typedef enum logic [1:0] {
      LAMP_OFF   = 2'd0,
      LAMP_RED   = 2'd1,
      LAMP_GREEN = 2'd2,
      LAMP_AMBER = 2'd3
   } lamp_type;

   typedef enum logic [2:0] {
      FUNC_SECOND  = 3'd0,
      FUNC_BLINK   = 3'd1,
      FUNC_MODE    = 3'd2,
      FUNC_ADD     = 3'd3,
      FUNC_CONFIRM = 3'd4
   } func_type;

   typedef enum logic [3:0] {
      MODE_NORMAL     = 4'b0001,
      MODE_EDIT_RED   = 4'b0010,
      MODE_EDIT_AMBER = 4'b0100,
      MODE_EDIT_GREEN = 4'b1000
   } mode_type;

   localparam logic [1:0] EDIT_CODE_NORMAL = 2'd0;
   localparam logic [1:0] EDIT_CODE_RED    = 2'd1;
   localparam logic [1:0] EDIT_CODE_AMBER  = 2'd2;
   localparam logic [1:0] EDIT_CODE_GREEN  = 2'd3;

   typedef struct packed {
      logic [1:0] lamp_a;
      logic [1:0] lamp_b;
      logic [6:0] display_a;
      logic [6:0] display_b;
      logic [1:0] edit_mode;
   } rsp_type;

   typedef struct packed {
      color_type  phase;
      logic [6:0] count;
   } light_type;

   function automatic logic [1:0] mode_code(input mode_type m);
      case (m)
         MODE_EDIT_RED:   mode_code = EDIT_CODE_RED;
         MODE_EDIT_AMBER: mode_code = EDIT_CODE_AMBER;
         MODE_EDIT_GREEN: mode_code = EDIT_CODE_GREEN;
         default:         mode_code = EDIT_CODE_NORMAL;
      endcase
   endfunction

   function automatic lamp_type lamp_of(input color_type c);
      case (c)
         COL_RED:   lamp_of = LAMP_RED;
         COL_AMBER: lamp_of = LAMP_AMBER;
         COL_GREEN: lamp_of = LAMP_GREEN;
         default:   lamp_of = LAMP_OFF;
      endcase
   endfunction

   // one second of countdown; a count of 0 or 1 advances the color
   function automatic light_type tick_light(input light_type cur,
                                            input logic [6:0] dur_r,
                                            input logic [6:0] dur_a,
                                            input logic [6:0] dur_g);
      light_type nxt;
      nxt = cur;
      if (cur.count <= 7'd1) begin
         case (cur.phase)
            COL_RED: begin
               nxt.phase = COL_GREEN;
               nxt.count = dur_g;
            end
            COL_GREEN: begin
               nxt.phase = COL_AMBER;
               nxt.count = dur_a;
            end
            default: begin
               nxt.phase = COL_RED;
               nxt.count = dur_r;
            end
         endcase
      end else begin
         nxt.count = cur.count - 7'd1;
      end
      return nxt;
   endfunction

endpackage

FILE: sv/tlc_core.sv
// controller state and its registered update for one event transfer
// depends on tlc_pkg
module tlc_core
   import tlc_pkg::*;
#(
   parameter int DEFAULT_RED   = TLC_DEFAULT_RED,
   parameter int DEFAULT_AMBER = TLC_DEFAULT_AMBER,
   parameter int DEFAULT_GREEN = TLC_DEFAULT_GREEN,
   parameter int MAX_SECONDS   = TLC_MAX_SECONDS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       accept,
   input  logic [2:0] func,
   input  logic       repeat_req,
   output rsp_type    rsp_in
);

   light_type  light_a_ff, light_a_in;
   light_type  light_b_ff, light_b_in;
   logic [6:0] dur_ff [3];
   logic [6:0] dur_in [3];
   logic [6:0] pend_ff [3];
   logic [6:0] pend_in [3];
   mode_type   mode_ff, mode_in;
   logic       press_ff, press_in;
   logic [1:0] blink_ff, blink_in;
   logic [7:0] idle_ff, idle_in;
   logic [7:0] timeout_ff;
   logic       restart;

   // pending value plus one, wrapping to zero past the limit
   function automatic logic [6:0] bump(input logic [6:0] p);
      logic [7:0] v;
      v = {1'b0, p} + 8'd1;
      if (v > 8'(MAX_SECONDS) || v[7]) begin
         v = 8'd0;
      end
      return v[6:0];
   endfunction

   always_comb begin
      light_a_in = light_a_ff;
      light_b_in = light_b_ff;
      dur_in     = dur_ff;
      pend_in    = pend_ff;
      mode_in    = mode_ff;
      press_in   = press_ff;
      blink_in   = blink_ff;
      idle_in    = idle_ff;
      restart    = 1'b0;
      if (accept) begin
         case (func_type'(func))
            FUNC_SECOND: begin
               if (mode_ff == MODE_NORMAL) begin
                  light_a_in = tick_light(light_a_ff, dur_ff[COL_RED], dur_ff[COL_AMBER],
                                          dur_ff[COL_GREEN]);
                  light_b_in = tick_light(light_b_ff, dur_ff[COL_RED], dur_ff[COL_AMBER],
                                          dur_ff[COL_GREEN]);
               end else begin
                  if (idle_ff != 8'hFF) begin
                     idle_in = idle_ff + 8'd1;
                  end
                  restart = (idle_in >= timeout_ff);
               end
            end
            FUNC_BLINK: begin
               case (mode_ff)
                  MODE_EDIT_RED:   blink_in = {1'b0, ~blink_ff[0]};
                  MODE_EDIT_AMBER: blink_in = ~blink_ff;
                  MODE_EDIT_GREEN: blink_in = {~blink_ff[1], 1'b0};
                  default:         blink_in = blink_ff;
               endcase
            end
            FUNC_MODE: begin
               blink_in = 2'b00;
               press_in = 1'b0;
               idle_in  = 8'd0;
               pend_in  = dur_ff;
               case (mode_ff)
                  MODE_NORMAL:     mode_in = MODE_EDIT_RED;
                  MODE_EDIT_RED:   mode_in = MODE_EDIT_AMBER;
                  MODE_EDIT_AMBER: mode_in = MODE_EDIT_GREEN;
                  default: begin
                     pend_in = pend_ff;
                     restart = 1'b1;
                  end
               endcase
            end
            FUNC_ADD: begin
               if (mode_ff != MODE_NORMAL) begin
                  if (!repeat_req) begin
                     press_in = 1'b1;
                  end
                  idle_in = 8'd0;
                  // each edit mode raises a linked pair of colors
                  case (mode_ff)
                     MODE_EDIT_RED: begin
                        pend_in[COL_RED]   = bump(pend_ff[COL_RED]);
                        pend_in[COL_GREEN] = bump(pend_ff[COL_GREEN]);
                     end
                     MODE_EDIT_AMBER: begin
                        pend_in[COL_AMBER] = bump(pend_ff[COL_AMBER]);
                        pend_in[COL_RED]   = bump(pend_ff[COL_RED]);
                     end
                     default: begin
                        pend_in[COL_GREEN] = bump(pend_ff[COL_GREEN]);
                        pend_in[COL_RED]   = bump(pend_ff[COL_RED]);
                     end
                  endcase
               end
            end
            FUNC_CONFIRM: begin
               if (mode_ff != MODE_NORMAL) begin
                  if (press_ff) begin
                     case (mode_ff)
                        MODE_EDIT_RED: begin
                           dur_in[COL_RED]   = pend_ff[COL_RED];
                           dur_in[COL_GREEN] = pend_ff[COL_GREEN];
                        end
                        MODE_EDIT_AMBER: begin
                           dur_in[COL_AMBER] = pend_ff[COL_AMBER];
                           dur_in[COL_RED]   = pend_ff[COL_RED];
                        end
                        default: begin
                           dur_in[COL_GREEN] = pend_ff[COL_GREEN];
                           dur_in[COL_RED]   = pend_ff[COL_RED];
                        end
                     endcase
                  end
                  restart = 1'b1;
               end
            end
            default: ;
         endcase
      end
      // restart reloads from the durations as just committed
      if (restart) begin
         light_a_in.phase = COL_RED;
         light_a_in.count = dur_in[COL_RED];
         light_b_in.phase = COL_GREEN;
         light_b_in.count = dur_in[COL_GREEN];
         mode_in          = MODE_NORMAL;
         press_in         = 1'b0;
         idle_in          = 8'd0;
      end
   end

   // result reflects the state after the event
   always_comb begin
      rsp_in.edit_mode = mode_code(mode_in);
      if (mode_in == MODE_NORMAL) begin
         rsp_in.lamp_a    = lamp_of(light_a_in.phase);
         rsp_in.lamp_b    = lamp_of(light_b_in.phase);
         rsp_in.display_a = light_a_in.count;
         rsp_in.display_b = light_b_in.count;
      end else begin
         rsp_in.lamp_a    = blink_in;
         rsp_in.lamp_b    = blink_in;
         rsp_in.display_b = 7'd0;
         case (mode_in)
            MODE_EDIT_RED:   rsp_in.display_a = pend_in[COL_RED];
            MODE_EDIT_AMBER: rsp_in.display_a = pend_in[COL_AMBER];
            default:         rsp_in.display_a = pend_in[COL_GREEN];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_a_ff.phase <= COL_RED;
         light_a_ff.count <= 7'(DEFAULT_RED);
         light_b_ff.phase <= COL_GREEN;
         light_b_ff.count <= 7'(DEFAULT_GREEN);
         dur_ff[COL_RED]    <= 7'(DEFAULT_RED);
         dur_ff[COL_AMBER]  <= 7'(DEFAULT_AMBER);
         dur_ff[COL_GREEN]  <= 7'(DEFAULT_GREEN);
         pend_ff[COL_RED]   <= 7'(DEFAULT_RED);
         pend_ff[COL_AMBER] <= 7'(DEFAULT_AMBER);
         pend_ff[COL_GREEN] <= 7'(DEFAULT_GREEN);
         mode_ff    <= MODE_NORMAL;
         press_ff   <= 1'b0;
         blink_ff   <= 2'b00;
         idle_ff    <= 8'd0;
         timeout_ff <= TLC_TIMEOUT_RESET;
      end else begin
         light_a_ff <= light_a_in;
         light_b_ff <= light_b_in;
         dur_ff     <= dur_in;
         pend_ff    <= pend_in;
         mode_ff    <= mode_in;
         press_ff   <= press_in;
         blink_ff   <= blink_in;
         idle_ff    <= idle_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

endmodule

FILE: sv/tlc_rsp_reg.sv
// result register with valid/ready toward the consumer
// depends on tlc_pkg
module tlc_rsp_reg
   import tlc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type rsp_in,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // a slot frees up in the same cycle the held result is taken
   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: sv/two_way_traffic_light_controller.sv
// two-way traffic light controller: the result of an event transfer is valid in the
// cycle after it; throughput one event per cycle while results are taken, limited by
// the single result register, which refills in the cycle its contents are taken
// synchronous active-high reset: A red, B green, default durations, normal mode,
// timeout 10 seconds, no result pending
module two_way_traffic_light_controller
   import tlc_pkg::*;
#(
   parameter int DEFAULT_RED   = TLC_DEFAULT_RED,
   parameter int DEFAULT_AMBER = TLC_DEFAULT_AMBER,
   parameter int DEFAULT_GREEN = TLC_DEFAULT_GREEN,
   parameter int MAX_SECONDS   = TLC_MAX_SECONDS
) (
   input  logic       clock,
   input  logic       reset,
   // timeout register write
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   // event channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_func,
   input  logic       req_repeat_req,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_lamp_a,
   output logic [1:0] rsp_lamp_b,
   output logic [6:0] rsp_display_a,
   output logic [6:0] rsp_display_b,
   output logic [1:0] rsp_edit_mode
);

`include "two_way_traffic_light_controller_macros.svh"

   logic    accept;
   logic    space;
   rsp_type rsp_in;
   rsp_type rsp_data;

   // an event is taken whenever the result slot is empty or being drained
   assign req_ready = space;
   assign accept    = req_valid && space;

   // state changes happen at the transfer edge, apart from timeout register writes;
   // the result is built from the updated state in the same cycle
   tlc_core #(
      .DEFAULT_RED   (DEFAULT_RED),
      .DEFAULT_AMBER (DEFAULT_AMBER),
      .DEFAULT_GREEN (DEFAULT_GREEN),
      .MAX_SECONDS   (MAX_SECONDS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .func        (req_func),
      .repeat_req  (req_repeat_req),
      .rsp_in      (rsp_in)
   );

   // result holding register, decouples the two channels
   tlc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .rsp_in    (rsp_in),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_lamp_a    = rsp_data.lamp_a;
   assign rsp_lamp_b    = rsp_data.lamp_b;
   assign rsp_display_a = rsp_data.display_a;
   assign rsp_display_b = rsp_data.display_b;
   assign rsp_edit_mode = rsp_data.edit_mode;

   // every event transfer produces a result next cycle
   `TLC_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_valid && req_ready, rsp_valid)
   // back-pressure only while a result is held
   `TLC_ASSERT_IMPL(a_ready_low_only_full, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   // in an edit mode the B display is blank
   `TLC_ASSERT_IMPL(a_edit_blank_b, clock, reset,
      rsp_valid && rsp_edit_mode != EDIT_CODE_NORMAL, rsp_display_b == 7'd0)
   // in an edit mode both lights show the same blink pattern
   `TLC_ASSERT_IMPL(a_edit_same_lamps, clock, reset,
      rsp_valid && rsp_edit_mode != EDIT_CODE_NORMAL, rsp_lamp_a == rsp_lamp_b)

endmodule
